// ----- hw/rtl/srsa_pkg.sv -----
// Shared types and constants of the sample ring slope and average block.
package srsa_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned ACC_W = 128;
  localparam int unsigned WIN_W = 5;
  localparam logic [WIN_W-1:0] WIN_RST = 5'd16;

  typedef enum logic [1:0] {
    DST_SXX = 2'd0,
    DST_SXY = 2'd1,
    DST_W   = 2'd2
  } mac_dst_e;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
    logic [1:0]  sh;
    logic        neg;
    mac_dst_e    dst;
  } mac_op_t;

  typedef struct packed {
    logic    clr_all;
    logic    clr_w;
    mac_op_t op;
  } mac_ctl_t;

  typedef struct packed {
    logic [31:0]        stime;
    logic signed [31:0] value;
  } ring_word_t;

endpackage

// ----- hw/rtl/srsa_if.sv -----
// Valid/ready channel interfaces for sample beats and result beats.
interface srsa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic [31:0]        sample_time;
  logic               restart;
  modport source (output valid, sample_value, sample_time, restart, input ready);
  modport sink (input valid, sample_value, sample_time, restart, output ready);
endinterface

interface srsa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] slope;
  logic               slope_valid;
  logic signed [31:0] window_average;
  logic [4:0]         stored_count;
  modport source (output valid, slope, slope_valid, window_average, stored_count,
                  input ready);
  modport sink (input valid, slope, slope_valid, window_average, stored_count,
                output ready);
endinterface

// ----- hw/rtl/srsa_ring.sv -----
// Ring memory of value/time pairs with one write port and a registered read port.
module srsa_ring #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  srsa_pkg::ring_word_t   wdata_i,
  input  logic [AW-1:0]          raddr_i,
  output srsa_pkg::ring_word_t   rdata_o
);
  import srsa_pkg::*;

  ring_word_t mem [DEPTH];
  ring_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/srsa_mac.sv -----
// Shared 32x32 multiplier with a registered product and three wide accumulators.
module srsa_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srsa_pkg::mac_ctl_t            ctl_i,
  output logic [srsa_pkg::ACC_W-1:0]    sxx_o,
  output logic [srsa_pkg::ACC_W-1:0]    sxy_o,
  output logic [srsa_pkg::ACC_W-1:0]    w_o
);
  import srsa_pkg::*;

  logic [63:0]      pp_q;
  logic [1:0]       sh_q;
  logic             neg_q;
  mac_dst_e         dst_q;
  logic             en_q;
  logic [ACC_W-1:0] sxx_q, sxy_q, w_q;
  logic [ACC_W-1:0] addend, term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= ctl_i.op.en;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q  <= 64'(ctl_i.op.a) * 64'(ctl_i.op.b);
    sh_q  <= ctl_i.op.sh;
    neg_q <= ctl_i.op.neg;
    dst_q <= ctl_i.op.dst;
  end

  // Partial products land on 32-bit chunk boundaries.
  assign addend = ACC_W'(pp_q) << {sh_q, 5'b00000};
  assign term   = neg_q ? (~addend + ACC_W'(1)) : addend;

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_all) begin
      sxx_q <= '0;
      sxy_q <= '0;
      w_q   <= '0;
    end else begin
      if (ctl_i.clr_w) begin
        w_q <= '0;
      end
      if (en_q) begin
        unique case (dst_q)
          DST_SXX: sxx_q <= sxx_q + term;
          DST_SXY: sxy_q <= sxy_q + term;
          DST_W:   w_q   <= w_q + term;
          default: ;
        endcase
      end
    end
  end

  assign sxx_o = sxx_q;
  assign sxy_o = sxy_q;
  assign w_o   = w_q;

endmodule

// ----- hw/rtl/srsa_div.sv -----
// Bit-serial signed divider with a 32-bit quotient, truncation toward zero and saturation.
module srsa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [srsa_pkg::ACC_W-1:0]    num_i,
  input  logic [srsa_pkg::ACC_W-1:0]    den_i,
  output logic                          done_o,
  output logic [31:0]                   quo_o
);
  import srsa_pkg::*;

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_CHK  = 4'b0010,
    DV_RUN  = 4'b0100,
    DV_DONE = 4'b1000
  } dv_state_e;

  dv_state_e        state_q;
  logic [ACC_W-1:0] rem_q, den_q, dsh_q;
  logic [31:0]      quo_q;
  logic [4:0]       cnt_q;
  logic             neg_q, sat_q;
  logic [ACC_W-1:0] den_top;
  logic             fits;

  assign den_top = {den_q[ACC_W-33:0], 32'b0};
  assign fits    = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      unique case (state_q)
        DV_IDLE: if (start_i) state_q <= DV_CHK;
        DV_CHK:  state_q <= (rem_q >= den_top) ? DV_DONE : DV_RUN;
        DV_RUN:  if (cnt_q == '0) state_q <= DV_DONE;
        DV_DONE: state_q <= DV_IDLE;
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          neg_q <= num_i[ACC_W-1];
          rem_q <= num_i[ACC_W-1] ? (~num_i + ACC_W'(1)) : num_i;
          den_q <= den_i;
        end
      end
      DV_CHK: begin
        // A magnitude at or above den * 2^32 cannot give a 32-bit quotient.
        sat_q <= rem_q >= den_top;
        dsh_q <= {den_q[ACC_W-32:0], 31'b0};
        quo_q <= '0;
        cnt_q <= 5'd31;
      end
      DV_RUN: begin
        if (fits) begin
          rem_q <= rem_q - dsh_q;
        end
        quo_q <= {quo_q[30:0], fits};
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q - 5'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (neg_q) begin
      quo_o = (sat_q || quo_q > 32'h8000_0000) ? 32'h8000_0000 : (~quo_q + 32'd1);
    end else begin
      quo_o = (sat_q || quo_q[31]) ? 32'h7fff_ffff : quo_q;
    end
  end

  assign done_o = state_q == DV_DONE;

endmodule

// ----- hw/rtl/sample_ring_slope_and_average_top.sv -----
// Top level of the sample ring slope and average block.
//
// Each beat on in_i appends a value/time pair to a ring of the last DEPTH pairs;
// restart empties the ring before the pair is stored. One result beat on out_o
// follows each input beat: the least-squares slope over all stored pairs but the
// newest (relative to the oldest pair), its valid flag, the mean of the newest
// min(window, count) values and the number of stored pairs. The averaging window
// is written through cfg_we_i/cfg_wdata_i; the user writes it only while the block is
// idle, as the block itself does not enforce this. One shared 32x32 multiplier and one
// bit-serial divider do all the multiplications and divisions under a sequencer, so
// in_i.ready is high only between items. For each item the sequencer reads every
// stored pair, forms two products for each fitted pair, builds the final numerator
// and denominator on the multiplier and runs up to two divisions, slope then average.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver only holds the block once the next result is done.
// Reset empties the ring and sets the window to 16.
module sample_ring_slope_and_average_top #(
  parameter int unsigned DEPTH = srsa_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [srsa_pkg::WIN_W-1:0]  cfg_wdata_i,
  srsa_in_if.sink                     in_i,
  srsa_out_if.source                  out_o
);
  import srsa_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > WIN_W) ? CW : WIN_W;
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [1:0]  IA_LAST = 2'd2;
  localparam logic [1:0]  PS_DEN_LAST = 2'd1;
  localparam logic [1:0]  PS_NUM_LAST = 2'd3;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_OLD  = 15'h0002,
    S_RD   = 15'h0004,
    S_DIF  = 15'h0008,
    S_MXX  = 15'h0010,
    S_MXY  = 15'h0020,
    S_DRN  = 15'h0040,
    S_PRD  = 15'h0080,
    S_PDRN = 15'h0100,
    S_DCHK = 15'h0200,
    S_SDIV = 15'h0400,
    S_SWT  = 15'h0800,
    S_ADIV = 15'h1000,
    S_AWT  = 15'h2000,
    S_OUT  = 15'h4000
  } state_e;

  state_e             state_q;
  logic [WIN_W-1:0]   win_q;
  logic [AW-1:0]      newest_q, n_q, l_q, k_q;
  logic [CW-1:0]      fill_q, m_q;
  ring_word_t         old_q;
  logic signed [63:0] sx_q, sy_q, asum_q;
  logic [31:0]        xm_q, ym_q;
  logic               xn_q, yn_q;
  logic [1:0]         ps_q, ia_q;
  logic               ib_q, num_ph_q;
  logic [ACC_W-1:0]   den_q;
  logic [31:0]        slope_q, avg_q;
  logic               sv_q;
  logic               out_valid_q, o_sv_q;
  logic [31:0]        o_slope_q, o_avg_q;
  logic [4:0]         o_cnt_q;

  logic               in_acc;
  logic [AW-1:0]      nxt_slot, n_new, mm1, l_new, rd_addr;
  logic [CW-1:0]      fill_new, m_new;
  logic [MW-1:0]      fill_ext, win_ext, cnt_ext;
  ring_word_t         wdata, rdata;
  logic [32:0]        xd, yd, xabs, yabs;
  logic               fitk, avgk;
  logic [ACC_W-1:0]   sxx, sxy, wacc, sxy_abs;
  logic [63:0]        sx_abs, sy_abs;
  logic [95:0]        pa;
  logic [63:0]        pb;
  logic               pneg;
  mac_ctl_t           mac_ctl;
  logic               div_start, div_done;
  logic [ACC_W-1:0]   div_num, div_den;
  logic [31:0]        div_quo;

  function automatic logic [AW-1:0] slot_at(logic [AW-1:0] nw, logic [AW-1:0] k);
    logic [AW:0] s;
    s = (nw >= k) ? ({1'b0, nw} - {1'b0, k}) : ({1'b0, nw} + DEPTH_W - {1'b0, k});
    return s[AW-1:0];
  endfunction

  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = state_q == S_IDLE;

  assign nxt_slot = (newest_q == AW'(DEPTH - 1)) ? '0 : newest_q + 1'b1;
  assign fill_new = in_i.restart ? CW'(1) :
                    (fill_q == CW'(DEPTH)) ? fill_q : fill_q + 1'b1;
  assign fill_ext = MW'(fill_new);
  assign win_ext  = MW'(win_q);
  assign m_new    = CW'((win_ext < fill_ext) ? win_ext : fill_ext);
  assign n_new    = AW'(fill_new - 1'b1);
  assign mm1      = (m_new == '0) ? '0 : AW'(m_new - 1'b1);
  assign l_new    = (n_new > mm1) ? n_new : mm1;

  assign wdata.stime = in_i.sample_time;
  assign wdata.value = in_i.sample_value;
  assign rd_addr = (state_q == S_OLD) ? slot_at(newest_q, n_q) : slot_at(newest_q, k_q);

  srsa_ring #(.DEPTH(DEPTH), .AW(AW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (nxt_slot),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Differences to the oldest pair; both magnitudes stay below 2^32.
  assign xd   = {1'b0, rdata.stime} - {1'b0, old_q.stime};
  assign yd   = {rdata.value[31], rdata.value} - {old_q.value[31], old_q.value};
  assign xabs = xd[32] ? (~xd + 33'd1) : xd;
  assign yabs = yd[32] ? (~yd + 33'd1) : yd;
  assign fitk = (k_q != '0) && (k_q <= n_q);
  assign avgk = CW'(k_q) < m_q;

  assign sx_abs  = sx_q[63] ? (~sx_q + 64'd1) : sx_q;
  assign sy_abs  = sy_q[63] ? (~sy_q + 64'd1) : sy_q;
  assign sxy_abs = sxy[ACC_W-1] ? (~sxy + ACC_W'(1)) : sxy;

  // Final products: n*Sxx - Sx*Sx, then n*Sxy - Sx*Sy.
  always_comb begin
    case (ps_q)
      2'd0: begin pa = sxx[95:0];     pb = 64'(n_q); pneg = 1'b0; end
      2'd1: begin pa = 96'(sx_abs);   pb = sx_abs;   pneg = 1'b1; end
      2'd2: begin pa = sxy_abs[95:0]; pb = 64'(n_q); pneg = sxy[ACC_W-1]; end
      default: begin
        pa = 96'(sx_abs);
        pb = sy_abs;
        pneg = ~(sx_q[63] ^ sy_q[63]);
      end
    endcase
  end

  always_comb begin
    mac_ctl = '0;
    mac_ctl.clr_all = in_acc;
    mac_ctl.clr_w = (state_q == S_DCHK) && !num_ph_q;
    mac_ctl.op.dst = DST_SXX;
    if (state_q == S_MXX) begin
      mac_ctl.op.en = 1'b1;
      mac_ctl.op.a = xm_q;
      mac_ctl.op.b = xm_q;
    end else if (state_q == S_MXY) begin
      mac_ctl.op.en = 1'b1;
      mac_ctl.op.a = xm_q;
      mac_ctl.op.b = ym_q;
      mac_ctl.op.neg = xn_q ^ yn_q;
      mac_ctl.op.dst = DST_SXY;
    end else if (state_q == S_PRD) begin
      mac_ctl.op.en = 1'b1;
      mac_ctl.op.a = pa[ia_q*32 +: 32];
      mac_ctl.op.b = ib_q ? pb[63:32] : pb[31:0];
      mac_ctl.op.sh = ia_q + {1'b0, ib_q};
      mac_ctl.op.neg = pneg;
      mac_ctl.op.dst = DST_W;
    end
  end

  srsa_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .sxx_o  (sxx),
    .sxy_o  (sxy),
    .w_o    (wacc)
  );

  assign div_start = (state_q == S_SDIV) || ((state_q == S_ADIV) && (m_q != '0));
  assign div_num   = (state_q == S_SDIV) ? wacc : {{64{asum_q[63]}}, asum_q};
  assign div_den   = (state_q == S_SDIV) ? den_q : ACC_W'(m_q);

  srsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_q       <= WIN_RST;
      newest_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      ps_q        <= '0;
      ia_q        <= '0;
      ib_q        <= 1'b0;
      num_ph_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            newest_q <= nxt_slot;
            fill_q   <= fill_new;
            n_q      <= n_new;
            m_q      <= m_new;
            l_q      <= l_new;
            k_q      <= '0;
            sx_q     <= '0;
            sy_q     <= '0;
            asum_q   <= '0;
            slope_q  <= '0;
            sv_q     <= 1'b0;
            avg_q    <= '0;
            ps_q     <= '0;
            ia_q     <= '0;
            ib_q     <= 1'b0;
            num_ph_q <= 1'b0;
            state_q  <= S_OLD;
          end
        end
        S_OLD: state_q <= S_RD;
        S_RD: begin
          // The first read cycle delivers the oldest pair.
          if (k_q == '0) begin
            old_q <= rdata;
          end
          state_q <= S_DIF;
        end
        S_DIF: begin
          if (avgk) begin
            asum_q <= asum_q + {{32{rdata.value[31]}}, rdata.value};
          end
          if (fitk) begin
            sx_q    <= sx_q + {{31{xd[32]}}, xd};
            sy_q    <= sy_q + {{31{yd[32]}}, yd};
            xm_q    <= xabs[31:0];
            ym_q    <= yabs[31:0];
            xn_q    <= xd[32];
            yn_q    <= yd[32];
            state_q <= S_MXX;
          end else if (k_q == l_q) begin
            state_q <= S_DRN;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_MXX: state_q <= S_MXY;
        S_MXY: begin
          if (k_q == l_q) begin
            state_q <= S_DRN;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_DRN: state_q <= (n_q == '0) ? S_ADIV : S_PRD;
        S_PRD: begin
          if (ib_q) begin
            ib_q <= 1'b0;
            if (ia_q == IA_LAST) begin
              ia_q <= '0;
              ps_q <= ps_q + 2'd1;
              if (ps_q == PS_DEN_LAST || ps_q == PS_NUM_LAST) begin
                state_q <= S_PDRN;
              end
            end else begin
              ia_q <= ia_q + 2'd1;
            end
          end else begin
            ib_q <= 1'b1;
          end
        end
        S_PDRN: state_q <= S_DCHK;
        S_DCHK: begin
          if (!num_ph_q) begin
            if (wacc[ACC_W-1] || wacc == '0) begin
              state_q <= S_ADIV;
            end else begin
              den_q    <= wacc;
              num_ph_q <= 1'b1;
              state_q  <= S_PRD;
            end
          end else begin
            state_q <= S_SDIV;
          end
        end
        S_SDIV: state_q <= S_SWT;
        S_SWT: begin
          if (div_done) begin
            slope_q <= div_quo;
            sv_q    <= 1'b1;
            state_q <= S_ADIV;
          end
        end
        S_ADIV: state_q <= (m_q == '0) ? S_OUT : S_AWT;
        S_AWT: begin
          if (div_done) begin
            avg_q   <= div_quo;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            o_slope_q   <= slope_q;
            o_sv_q      <= sv_q;
            o_avg_q     <= avg_q;
            o_cnt_q     <= cnt_ext[4:0];
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cnt_ext = MW'(fill_q);

  assign out_o.valid          = out_valid_q;
  assign out_o.slope          = o_slope_q;
  assign out_o.slope_valid    = o_sv_q;
  assign out_o.window_average = o_avg_q;
  assign out_o.stored_count   = o_cnt_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill count above ring depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input ready right after an accepted beat");

  a_invalid_slope_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.slope_valid) |-> (out_o.slope == '0))
    else $error("nonzero slope with slope_valid low");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.stored_count != '0))
    else $error("result beat with empty ring count");

endmodule
